### src/eebw_pkg.sv
// ----------------------------------------------------------------------------
// eebw_pkg: shared types and constants of the EEPROM block writer
// Opcodes, writer phases, register indexes, transaction structs and the
// reflected CCITT CRC byte update.
// ----------------------------------------------------------------------------
package eebw_pkg;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int CRC_W    = 16;
   localparam int REG_W    = 12;
   localparam int EADDR_W  = 12;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W = 2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_START       = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READY       = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_VERIFY_BYTE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_VERIFY_END  = 2'd3;

   // writer phases
   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DATA = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CRC  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BASE_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_ADDR       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH   = 2'd2;

   // crc constants
   localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

   // number of crc bytes written after the data
   localparam logic [REG_W-1:0] CRC_BYTES = 12'd2;

   typedef struct packed {
      logic [REG_W-1:0] data_base_addr;
      logic [REG_W-1:0] crc_addr;
      logic [REG_W-1:0] block_length;
   } cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   stored_byte;
      logic [CRC_W-1:0]    stored_crc;
   } req_item_type;

   typedef struct packed {
      logic [EADDR_W-1:0] eeprom_addr;
      logic [BYTE_W-1:0]  write_byte;
      logic               write_enable;
      logic [PHASE_W-1:0] phase;
      logic               job_done;
      logic               crc_ok;
      logic [CRC_W-1:0]   computed_crc;
   } rsp_item_type;

   // one byte of the reflected ccitt update, lsb first
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] r;
      r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int i = 0; i < BYTE_W; i++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

endpackage

### src/eebw_req_if.sv
// ----------------------------------------------------------------------------
// eebw_req_if: request channel of the EEPROM block writer
// Valid/ready channel carrying one opcode transaction with its bytes.
// ----------------------------------------------------------------------------
interface eebw_req_if;
   import eebw_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   data_byte;
   logic [BYTE_W-1:0]   stored_byte;
   logic [CRC_W-1:0]    stored_crc;

   modport source (output valid, output opcode, output data_byte,
                   output stored_byte, output stored_crc, input ready);
   modport sink   (input valid, input opcode, input data_byte,
                   input stored_byte, input stored_crc, output ready);
endinterface

### src/eebw_rsp_if.sv
// ----------------------------------------------------------------------------
// eebw_rsp_if: response channel of the EEPROM block writer
// Valid/ready channel carrying one result transaction per request.
// ----------------------------------------------------------------------------
interface eebw_rsp_if;
   import eebw_pkg::*;

   logic                valid;
   logic                ready;
   logic [EADDR_W-1:0]  eeprom_addr;
   logic [BYTE_W-1:0]   write_byte;
   logic                write_enable;
   logic [PHASE_W-1:0]  phase;
   logic                job_done;
   logic                crc_ok;
   logic [CRC_W-1:0]    computed_crc;

   modport source (output valid, output eeprom_addr, output write_byte,
                   output write_enable, output phase, output job_done,
                   output crc_ok, output computed_crc, input ready);
   modport sink   (input valid, input eeprom_addr, input write_byte,
                   input write_enable, input phase, input job_done,
                   input crc_ok, input computed_crc, output ready);
endinterface

### src/eebw_csr.sv
// ----------------------------------------------------------------------------
// eebw_csr: configuration registers
// Holds base address, crc address and block length, written by index.
// ----------------------------------------------------------------------------
module eebw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [eebw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [eebw_pkg::REG_W-1:0]     csr_write_data,
   output eebw_pkg::cfg_type             cfg
);
   import eebw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DATA_BASE_ADDR: cfg_in.data_base_addr = csr_write_data;
            CSR_CRC_ADDR:       cfg_in.crc_addr       = csr_write_data;
            CSR_BLOCK_LENGTH:   cfg_in.block_length   = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_base_addr <= '0;
         cfg_ff.crc_addr       <= '0;
         cfg_ff.block_length   <= 12'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/eebw_in_stage.sv
// ----------------------------------------------------------------------------
// eebw_in_stage: request input register
// Captures one request transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module eebw_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  eebw_pkg::req_item_type req_item,
   input  logic                   advance,
   output logic                   item_valid,
   output eebw_pkg::req_item_type item
);
   import eebw_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // free when empty or when the core consumes the held item this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### src/eebw_core.sv
// ----------------------------------------------------------------------------
// eebw_core: writer sequencer, verifier and result register
// Processes one held request per cycle while the result register is free or
// taken, updates writer and verify state and registers the result transaction.
// ----------------------------------------------------------------------------
module eebw_core #(
   parameter int ADDR_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  eebw_pkg::cfg_type      cfg,
   input  logic                   item_valid,
   input  eebw_pkg::req_item_type item,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output eebw_pkg::rsp_item_type rsp_item
);
   import eebw_pkg::*;

   localparam int WIDE_W = ADDR_BITS + REG_W;

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [REG_W-1:0]     left_ff, left_in;
   logic [CRC_W-1:0]     wcrc_ff, wcrc_in;
   logic [CRC_W-1:0]     vcrc_ff, vcrc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 fire;

   logic [WIDE_W-1:0]    base_wide, crca_wide, addr_out_wide;
   logic [ADDR_BITS-1:0] base_addr, crc_addr;
   logic [ADDR_BITS-1:0] addr_out;
   logic [BYTE_W-1:0]    wbyte;
   logic                 wen, done, ok;
   logic [CRC_W-1:0]     crc_out;

   // pipeline control
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign fire         = item_valid && advance;
   assign rsp_valid_in = advance ? item_valid : rsp_valid_ff;

   // configured addresses wrapped to the address width
   assign base_wide = {{ADDR_BITS{1'b0}}, cfg.data_base_addr};
   assign crca_wide = {{ADDR_BITS{1'b0}}, cfg.crc_addr};
   assign base_addr = base_wide[ADDR_BITS-1:0];
   assign crc_addr  = crca_wide[ADDR_BITS-1:0];

   // next state and result for the held transaction
   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      wcrc_in  = wcrc_ff;
      vcrc_in  = vcrc_ff;
      addr_out = addr_ff;
      wbyte    = '0;
      wen      = 1'b0;
      done     = 1'b0;
      ok       = 1'b0;
      crc_out  = wcrc_ff;
      unique case (item.opcode)
         OP_START: begin
            wcrc_in = CRC_SEED;
            if (cfg.block_length == '0) begin
               phase_in = PH_CRC;
               addr_in  = crc_addr;
               left_in  = CRC_BYTES;
            end else begin
               phase_in = PH_DATA;
               addr_in  = base_addr;
               left_in  = cfg.block_length;
            end
            addr_out = addr_in;
            crc_out  = CRC_SEED;
         end
         OP_READY: begin
            unique case (phase_ff)
               PH_DATA: begin
                  wbyte   = item.data_byte;
                  wcrc_in = crc_fold(wcrc_ff, item.data_byte);
                  addr_in = addr_ff + 1'b1;
                  left_in = left_ff - 1'b1;
                  wen     = (wbyte != item.stored_byte);
                  // last data byte hands over to the crc bytes
                  if (left_ff == 12'd1) begin
                     phase_in = PH_CRC;
                     addr_in  = crc_addr;
                     left_in  = CRC_BYTES;
                  end
               end
               PH_CRC: begin
                  wbyte   = (left_ff == 12'd1) ? wcrc_ff[CRC_W-1:BYTE_W]
                                               : wcrc_ff[BYTE_W-1:0];
                  addr_in = addr_ff + 1'b1;
                  left_in = left_ff - 1'b1;
                  wen     = (wbyte != item.stored_byte);
                  if (left_ff == 12'd1) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            crc_out = wcrc_in;
         end
         OP_VERIFY_BYTE: begin
            vcrc_in = crc_fold(vcrc_ff, item.data_byte);
            crc_out = vcrc_in;
         end
         OP_VERIFY_END: begin
            crc_out = vcrc_ff;
            ok      = (vcrc_ff == item.stored_crc);
            vcrc_in = CRC_SEED;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // result assembly, address shown in its low 12 bits
   assign addr_out_wide = {{REG_W{1'b0}}, addr_out};

   always_comb begin
      rsp_in.eeprom_addr  = addr_out_wide[EADDR_W-1:0];
      rsp_in.write_byte   = wbyte;
      rsp_in.write_enable = wen;
      rsp_in.phase        = phase_in;
      rsp_in.job_done     = done;
      rsp_in.crc_ok       = ok;
      rsp_in.computed_crc = crc_out;
   end

   // writer and verifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         addr_ff      <= '0;
         left_ff      <= '0;
         wcrc_ff      <= CRC_SEED;
         vcrc_ff      <= CRC_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            addr_ff  <= addr_in;
            left_ff  <= left_in;
            wcrc_ff  <= wcrc_in;
            vcrc_ff  <= vcrc_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a finished job leaves the writer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.job_done |-> rsp_ff.phase == PH_IDLE)
      else $error("job_done reported with writer not idle");

   // crc phase only ever has one or two bytes left
   a_crc_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CRC |-> (left_ff == 12'd1 || left_ff == 12'd2))
      else $error("crc phase with bad byte count");

   // a compare result never comes with a programming request
   a_ok_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.crc_ok |-> !rsp_ff.write_enable && !rsp_ff.job_done)
      else $error("crc_ok together with write activity");

   // a stalled result freezes the writer state
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(phase_ff) && $stable(addr_ff)
                                     && $stable(wcrc_ff) && $stable(vcrc_ff))
      else $error("state changed while result stalled");

endmodule

### src/crc_protected_eeprom_block_writer_unit.sv
// ----------------------------------------------------------------------------
// crc_protected_eeprom_block_writer_unit: CRC-protected EEPROM block writer
// Writes a data block with a trailing CRC-16 and verifies read-back blocks.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per event: start write, EEPROM ready
//   (new byte plus the byte now stored), verify byte, or verify end with the
//   stored CRC word. rsp_chan returns exactly one result transaction per
//   request: address handled, byte to program, write enable, writer phase,
//   job done, CRC compare result and the running CRC.
//   The csr_ port writes data_base_addr, crc_addr and block_length; write it
//   only while no transaction is in flight.
//   The request is held in the input register, then the CRC byte update and
//   compare feed the result register, where the result waits until it is
//   taken. Throughput is one transaction per cycle while the receiver takes
//   results, set by the single 8-bit CRC fold between those registers.
//   When the receiver stalls, the result is held, the input register still
//   takes one more transaction, and then req_chan.ready drops.
//   Reset (synchronous) empties both registers, sets the writer idle, both
//   CRCs to 0xFFFF and block_length to 1.
// ----------------------------------------------------------------------------
module crc_protected_eeprom_block_writer_unit #(
   parameter int ADDR_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   eebw_req_if.sink                       req_chan,
   eebw_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [eebw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [eebw_pkg::REG_W-1:0]     csr_write_data
);
   import eebw_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         advance;
   logic         rsp_valid;

   // request payload bundle
   always_comb begin
      req_item.opcode      = req_chan.opcode;
      req_item.data_byte   = req_chan.data_byte;
      req_item.stored_byte = req_chan.stored_byte;
      req_item.stored_crc  = req_chan.stored_crc;
   end

   eebw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   eebw_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   eebw_core #(
      .ADDR_BITS (ADDR_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_item   (rsp_item)
   );

   // response channel drive
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.eeprom_addr  = rsp_item.eeprom_addr;
   assign rsp_chan.write_byte   = rsp_item.write_byte;
   assign rsp_chan.write_enable = rsp_item.write_enable;
   assign rsp_chan.phase        = rsp_item.phase;
   assign rsp_chan.job_done     = rsp_item.job_done;
   assign rsp_chan.crc_ok       = rsp_item.crc_ok;
   assign rsp_chan.computed_crc = rsp_item.computed_crc;

endmodule

### test/crc_protected_eeprom_block_writer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_protected_eeprom_block_writer_unit_test: self-checking bench of the writer
// A directed table walks the corner cases of the block writer and verifier,
// then register settings are swept with random write jobs, verify runs and
// noise. Every result transaction is compared with its table value or a local prediction.
// ----------------------------------------------------------------------------
module crc_protected_eeprom_block_writer_unit_test;
   import eebw_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 146;

   typedef enum logic {ROW_REQ, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [REG_W-1:0]       reg_val;
      req_item_type           item;
      logic                   has_want;
      rsp_item_type           want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]      csr_write_data;

   eebw_req_if req_chan ();
   eebw_rsp_if rsp_chan ();

   crc_protected_eeprom_block_writer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow of the writer registers and state
   cfg_type              writer_cfg;
   logic [PHASE_W-1:0]   wr_phase;
   logic [EADDR_W-1:0]   wr_addr;
   logic [REG_W-1:0]     wr_left;
   logic [CRC_W-1:0]     wr_crc;
   logic [CRC_W-1:0]     vf_crc;

   rsp_item_type         writer_results_due [$];
   stim_row_type         corner_rows [$];
   int unsigned          mismatch_count;
   int unsigned          idle_cycles;
   bit                   sender_calm;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // reflected ccitt byte update, lsb first
   function automatic logic [CRC_W-1:0] ccitt_byte_update(logic [CRC_W-1:0] crc,
                                                          logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (BYTE_W) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      return acc;
   endfunction

   // one transaction through the writer and verifier, updating the shadow state
   function automatic rsp_item_type step_block_writer(req_item_type it);
      rsp_item_type res;
      logic         done;
      res  = '0;
      done = 1'b0;
      res.eeprom_addr = wr_addr;
      case (it.opcode)
         OP_START: begin
            wr_crc   = CRC_SEED;
            wr_addr  = writer_cfg.data_base_addr;
            wr_left  = writer_cfg.block_length;
            wr_phase = PH_DATA;
            // empty block goes straight to the crc bytes
            if (wr_left == '0) begin
               wr_phase = PH_CRC;
               wr_addr  = writer_cfg.crc_addr;
               wr_left  = CRC_BYTES;
            end
            res.eeprom_addr  = wr_addr;
            res.computed_crc = wr_crc;
         end
         OP_READY: begin
            if (wr_phase == PH_DATA) begin
               res.write_byte = it.data_byte;
               wr_crc  = ccitt_byte_update(wr_crc, it.data_byte);
               wr_addr = wr_addr + 1'b1;
               wr_left = wr_left - 1'b1;
               if (wr_left == '0) begin
                  wr_phase = PH_CRC;
                  wr_addr  = writer_cfg.crc_addr;
                  wr_left  = CRC_BYTES;
               end
            end else if (wr_phase == PH_CRC) begin
               // low byte first, then high byte
               res.write_byte = (wr_left == 12'd1) ? wr_crc[15:8] : wr_crc[7:0];
               wr_addr = wr_addr + 1'b1;
               wr_left = wr_left - 1'b1;
               if (wr_left == '0) begin
                  wr_phase = PH_IDLE;
                  done     = 1'b1;
               end
            end else begin
               wr_phase = PH_IDLE;
            end
            if (wr_phase != PH_IDLE || done) begin
               res.write_enable = (res.write_byte != it.stored_byte);
            end
            res.job_done     = done;
            res.computed_crc = wr_crc;
         end
         OP_VERIFY_BYTE: begin
            vf_crc = ccitt_byte_update(vf_crc, it.data_byte);
            res.computed_crc = vf_crc;
         end
         default: begin
            res.computed_crc = vf_crc;
            res.crc_ok       = (vf_crc == it.stored_crc);
            vf_crc           = CRC_SEED;
         end
      endcase
      res.phase = wr_phase;
      return res;
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic stim_row_type req_row(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] d,
                                            logic [BYTE_W-1:0] s, logic [CRC_W-1:0] c);
      stim_row_type row;
      row          = '{kind: ROW_REQ, default: '0};
      row.kind     = ROW_REQ;
      row.item     = req_item_type'{op, d, s, c};
      row.has_want = 1'b0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] d,
                                              logic [BYTE_W-1:0] s, logic [CRC_W-1:0] c,
                                              rsp_item_type want);
      stim_row_type row;
      row          = req_row(op, d, s, c);
      row.has_want = 1'b1;
      row.want     = want;
      return row;
   endfunction

   function automatic stim_row_type reg_row(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      stim_row_type row;
      row         = '{kind: ROW_REG, default: '0};
      row.kind    = ROW_REG;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   // drive one request transaction, called and returning at a falling edge
   task automatic push_request(req_item_type it, logic has_want, rsp_item_type want);
      int unsigned  gap;
      rsp_item_type predicted;
      gap = sender_calm ? 0 : pick_idle();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= it.opcode;
      req_chan.data_byte   <= it.data_byte;
      req_chan.stored_byte <= it.stored_byte;
      req_chan.stored_crc  <= it.stored_crc;
      do @(posedge clock); while (!req_chan.ready);
      predicted = step_block_writer(it);
      writer_results_due.push_back(has_want ? want : predicted);
      @(negedge clock);
   endtask

   // leave the request channel quiet and wait until every result is back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (writer_results_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_DATA_BASE_ADDR: writer_cfg.data_base_addr = val;
         CSR_CRC_ADDR:       writer_cfg.crc_addr       = val;
         CSR_BLOCK_LENGTH:   writer_cfg.block_length   = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // mostly well-formed write jobs and verify runs, with restarts and noise
   task automatic run_random_items(int unsigned n_items);
      req_item_type it;
      int unsigned  r;
      int unsigned  counted;
      counted = 0;
      while (counted < n_items) begin
         it.data_byte   = BYTE_W'($urandom_range(0, 255));
         it.stored_byte = BYTE_W'($urandom_range(0, 255));
         it.stored_crc  = CRC_W'($urandom_range(0, 65535));
         r = $urandom_range(0, 99);
         if (wr_phase != PH_IDLE) begin
            if (r < 87)      it.opcode = OP_READY;
            else if (r < 93) it.opcode = OP_VERIFY_BYTE;
            else if (r < 96) it.opcode = OP_VERIFY_END;
            else             it.opcode = OP_START;
         end else begin
            if (r < 45)      it.opcode = OP_START;
            else if (r < 80) it.opcode = OP_VERIFY_BYTE;
            else if (r < 93) it.opcode = OP_VERIFY_END;
            else             it.opcode = OP_READY;
         end
         // make unchanged bytes and matching crc words common
         if (it.opcode == OP_READY && $urandom_range(0, 9) < 3) begin
            if (wr_phase == PH_DATA)
               it.stored_byte = it.data_byte;
            else if (wr_phase == PH_CRC)
               it.stored_byte = (wr_left == 12'd1) ? wr_crc[15:8] : wr_crc[7:0];
         end
         if (it.opcode == OP_VERIFY_END && $urandom_range(0, 9) < 6) begin
            it.stored_crc = vf_crc;
         end
         if (!(it.opcode == OP_READY && wr_phase == PH_IDLE)) counted++;
         push_request(it, 1'b0, '0);
      end
   endtask

   // result sink with random stalls
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         stall = pick_idle();
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // check each result transaction against the oldest prediction
   task automatic check_field(string field_name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                  $time, field_name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.eeprom_addr, rsp_chan.write_byte, rsp_chan.write_enable,
                rsp_chan.phase, rsp_chan.job_done, rsp_chan.crc_ok, rsp_chan.computed_crc};
         if (writer_results_due.size() == 0) begin
            $display("%0t: result transaction with none expected, got 0x%0h", $time, got);
            mismatch_count++;
         end else begin
            want = writer_results_due.pop_front();
            check_field("eeprom_addr", 16'(want.eeprom_addr), 16'(got.eeprom_addr));
            check_field("write_byte", 16'(want.write_byte), 16'(got.write_byte));
            check_field("write_enable", 16'(want.write_enable), 16'(got.write_enable));
            check_field("phase", 16'(want.phase), 16'(got.phase));
            check_field("job_done", 16'(want.job_done), 16'(got.job_done));
            check_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
            check_field("computed_crc", want.computed_crc, got.computed_crc);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : main_sequence
      int unsigned p;
      logic [REG_W-1:0] base;
      logic [REG_W-1:0] crc_at;
      logic [REG_W-1:0] len;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = OP_START;
      req_chan.data_byte   = '0;
      req_chan.stored_byte = '0;
      req_chan.stored_crc  = '0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_DATA_BASE_ADDR;
      csr_write_data       = '0;
      mismatch_count       = 0;
      idle_cycles          = 0;
      sender_calm          = 1'b0;
      writer_cfg           = cfg_type'{12'd0, 12'd0, 12'd1};
      wr_phase             = PH_IDLE;
      wr_addr              = '0;
      wr_left              = '0;
      wr_crc               = CRC_SEED;
      vf_crc               = CRC_SEED;

      // corner cases, starting from the reset settings
      corner_rows.push_back(typed_row(OP_READY, 8'hFF, 8'h00, 16'h0000,
                            rsp_item_type'{12'h000, 8'h00, 1'b0, PH_IDLE, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(typed_row(OP_VERIFY_END, 8'h00, 8'h00, 16'hFFFF,
                            rsp_item_type'{12'h000, 8'h00, 1'b0, PH_IDLE, 1'b0, 1'b1, CRC_SEED}));
      corner_rows.push_back(typed_row(OP_VERIFY_END, 8'h00, 8'h00, 16'h0000,
                            rsp_item_type'{12'h000, 8'h00, 1'b0, PH_IDLE, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(typed_row(OP_START, 8'h00, 8'h00, 16'h0000,
                            rsp_item_type'{12'h000, 8'h00, 1'b0, PH_DATA, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(req_row(OP_READY, 8'hFF, 8'hFF, 16'hFFFF));
      corner_rows.push_back(req_row(OP_READY, 8'h00, 8'h00, 16'h0000));
      corner_rows.push_back(req_row(OP_READY, 8'h00, 8'hFF, 16'hFFFF));
      corner_rows.push_back(req_row(OP_READY, 8'h5A, 8'hA5, 16'h0000));
      corner_rows.push_back(req_row(OP_VERIFY_BYTE, 8'hFF, 8'h00, 16'h0000));
      corner_rows.push_back(req_row(OP_VERIFY_BYTE, 8'h00, 8'hFF, 16'hFFFF));
      corner_rows.push_back(req_row(OP_VERIFY_END, 8'h00, 8'h00, 16'hFFFF));
      corner_rows.push_back(typed_row(OP_START, 8'hFF, 8'hFF, 16'hFFFF,
                            rsp_item_type'{12'h000, 8'h00, 1'b0, PH_DATA, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(req_row(OP_READY, 8'h5A, 8'hA5, 16'h0000));
      // restart while the crc bytes are pending
      corner_rows.push_back(typed_row(OP_START, 8'h00, 8'h00, 16'h0000,
                            rsp_item_type'{12'h000, 8'h00, 1'b0, PH_DATA, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(req_row(OP_READY, 8'h81, 8'h81, 16'h0000));
      // empty block with the crc word wrapping past the top address
      corner_rows.push_back(reg_row(CSR_BLOCK_LENGTH, 12'h000));
      corner_rows.push_back(reg_row(CSR_CRC_ADDR, 12'hFFF));
      corner_rows.push_back(typed_row(OP_START, 8'h00, 8'h00, 16'h0000,
                            rsp_item_type'{12'hFFF, 8'h00, 1'b0, PH_CRC, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(typed_row(OP_READY, 8'h3C, 8'h00, 16'h0000,
                            rsp_item_type'{12'hFFF, 8'hFF, 1'b1, PH_CRC, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(typed_row(OP_READY, 8'hC3, 8'hFF, 16'h0000,
                            rsp_item_type'{12'h000, 8'hFF, 1'b0, PH_IDLE, 1'b1, 1'b0, CRC_SEED}));
      // data block wrapping past the top address
      corner_rows.push_back(reg_row(CSR_DATA_BASE_ADDR, 12'hFFF));
      corner_rows.push_back(reg_row(CSR_BLOCK_LENGTH, 12'h002));
      corner_rows.push_back(typed_row(OP_START, 8'h00, 8'h00, 16'h0000,
                            rsp_item_type'{12'hFFF, 8'h00, 1'b0, PH_DATA, 1'b0, 1'b0, CRC_SEED}));
      corner_rows.push_back(req_row(OP_READY, 8'h12, 8'h34, 16'h0000));
      corner_rows.push_back(req_row(OP_READY, 8'h80, 8'h80, 16'h0000));
      corner_rows.push_back(req_row(OP_READY, 8'h00, 8'h00, 16'h0000));
      corner_rows.push_back(req_row(OP_READY, 8'h00, 8'hFF, 16'h0000));

      // reset
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (corner_rows[i]) begin
         if (corner_rows[i].kind == ROW_REG) begin
            wait_drained();
            write_reg(corner_rows[i].reg_idx, corner_rows[i].reg_val);
         end else begin
            push_request(corner_rows[i].item, corner_rows[i].has_want, corner_rows[i].want);
         end
      end

      // random jobs over a sweep of register settings
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin base = 12'h000; crc_at = 12'hFFF; len = 12'hFFF; end
            1: begin base = 12'hFFF; crc_at = 12'hFFF; len = 12'h000; end
            2: begin base = 12'hFFE; crc_at = 12'h000; len = 12'h003; end
            3: begin base = 12'h000; crc_at = 12'h000; len = 12'h001; end
            default: begin
               base   = REG_W'($urandom_range(0, 4095));
               crc_at = REG_W'($urandom_range(0, 4095));
               len    = REG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 10));
            end
         endcase
         write_reg(CSR_DATA_BASE_ADDR, base);
         write_reg(CSR_CRC_ADDR, crc_at);
         write_reg(CSR_BLOCK_LENGTH, len);
         sender_calm = ($urandom_range(0, 3) == 0);
         run_random_items(PHASE_ITEMS);
      end

      // drain and let the pipeline settle
      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
src/eebw_pkg.sv
src/eebw_req_if.sv
src/eebw_rsp_if.sv
src/eebw_csr.sv
src/eebw_in_stage.sv
src/eebw_core.sv
src/crc_protected_eeprom_block_writer_unit.sv
test/crc_protected_eeprom_block_writer_unit_test.sv
